>>> rtl/bms_pkg.sv
// Shared types, character codes and bracket helpers for the bracket match scanner.
package bms_pkg;

  localparam int POS_W   = 20;
  localparam int CH_W    = 16;
  localparam int DEPTH_W = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CH_W-1:0] CH_LPAREN = 16'h0028;
  localparam logic [CH_W-1:0] CH_RPAREN = 16'h0029;
  localparam logic [CH_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CH_W-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CH_W-1:0] CH_LSQ    = 16'h005B;
  localparam logic [CH_W-1:0] CH_RSQ    = 16'h005D;
  localparam logic [CH_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CH_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CH_W-1:0] CH_SLASH  = 16'h002F;
  localparam logic [CH_W-1:0] CH_STAR   = 16'h002A;
  localparam logic [CH_W-1:0] CH_NL     = 16'h000A;
  localparam logic [CH_W-1:0] CH_BSLASH = 16'h005C;

  typedef enum logic [4:0] {
    LX_NORMAL = 5'b00001,
    LX_STRING = 5'b00010,
    LX_CHAR   = 5'b00100,
    LX_LINE   = 5'b01000,
    LX_BLOCK  = 5'b10000
  } lex_t;

  typedef enum logic [2:0] {
    ST_SEARCH  = 3'd0,
    ST_FOUND   = 3'd1,
    ST_NOMATCH = 3'd2,
    ST_NOTBR   = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  // Odd codes are opening brackets; each closer follows its opener.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LPAREN = 3'd1,
    KIND_RPAREN = 3'd2,
    KIND_LBRACE = 3'd3,
    KIND_RBRACE = 3'd4,
    KIND_LSQ    = 3'd5,
    KIND_RSQ    = 3'd6
  } kind_t;

  typedef struct packed {
    logic              start_scan;
    logic [POS_W-1:0]  position;
    logic [CH_W-1:0]   ch;
    logic [CH_W-1:0]   ch_after;
    logic              has_after;
    logic [CH_W-1:0]   ch_before;
    logic              has_before;
    logic              last_in_scan;
  } item_t;

  typedef struct packed {
    lex_t               lex;
    logic [DEPTH_W-1:0] depth;
    kind_t              kind;
    logic               skip;
    logic               done;
  } scan_state_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  match_position;
  } result_t;

  function automatic kind_t kind_of(logic [CH_W-1:0] c);
    kind_t k;
    k = KIND_NONE;
    if (c == CH_LPAREN) k = KIND_LPAREN;
    if (c == CH_RPAREN) k = KIND_RPAREN;
    if (c == CH_LBRACE) k = KIND_LBRACE;
    if (c == CH_RBRACE) k = KIND_RBRACE;
    if (c == CH_LSQ)    k = KIND_LSQ;
    if (c == CH_RSQ)    k = KIND_RSQ;
    return k;
  endfunction

  function automatic logic [CH_W-1:0] kind_char(kind_t k);
    logic [CH_W-1:0] c;
    unique case (k)
      KIND_LPAREN: c = CH_LPAREN;
      KIND_RPAREN: c = CH_RPAREN;
      KIND_LBRACE: c = CH_LBRACE;
      KIND_RBRACE: c = CH_RBRACE;
      KIND_LSQ:    c = CH_LSQ;
      KIND_RSQ:    c = CH_RSQ;
      default:     c = '0;
    endcase
    return c;
  endfunction

  function automatic kind_t partner_of(kind_t k);
    kind_t p;
    unique case (k)
      KIND_LPAREN: p = KIND_RPAREN;
      KIND_RPAREN: p = KIND_LPAREN;
      KIND_LBRACE: p = KIND_RBRACE;
      KIND_RBRACE: p = KIND_LBRACE;
      KIND_LSQ:    p = KIND_RSQ;
      KIND_RSQ:    p = KIND_LSQ;
      default:     p = KIND_NONE;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/bracket_match_scanner.sv
// Top level of the bracket match scanner: input register, scan state and result register.
//
//  Channel | Ports                      | Contents
//  --------+----------------------------+------------------------------------------
//  input   | in_tvalid/tready/tdata/... | one character per transfer, scan order
//  result  | out_tvalid/tready/tdata    | one status per input transfer
//
//  Throughput is one character per cycle while out_tready is high; each result
//  passes through the input register, then the result register.
//  The scan state is updated in the same cycle a character moves into the
//  result register, so the following character sees it with no bubble.
//  Reset leaves the scanner idle with no scan running.
//  While out_tready is low the result holds, one more character is taken into
//  the input register, then in_tready drops.
module bracket_match_scanner
  import bms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // position[19:0], ch[35:20], ch_after[51:36], has_after[52],
  // ch_before[68:53], has_before[69], zero[71:70]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // start_scan[0]
  input  logic                   in_tlast,   // last_in_scan
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[2:0], match_position[22:3], zero[23]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  result_t     step_res;
  item_t       in_item;
  logic        s1_move;

  assign in_item = '{
    start_scan:   in_tuser,
    position:     in_tdata[19:0],
    ch:           in_tdata[35:20],
    ch_after:     in_tdata[51:36],
    has_after:    in_tdata[52],
    ch_before:    in_tdata[68:53],
    has_before:   in_tdata[69],
    last_in_scan: in_tlast
  };

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  bms_step u_step (
    .item (s1_item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{lex: LX_NORMAL, depth: '0, kind: KIND_NONE, skip: 1'b0, done: 1'b1};
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_move) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_item_r <= in_item;
    if (s1_move) out_res_r <= step_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.match_position, out_res_r.status};

`ifndef NO_ASSERTIONS
  a_run_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.done |-> state_r.kind != KIND_NONE)
    else $error("scan running without a bracket kind");

  a_skip_forward: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.skip |-> (!state_r.done && state_r.kind[0]))
    else $error("skip pending outside a forward scan");

  a_found_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && step_res.status == ST_FOUND) |=> (state_r.done && out_valid_r))
    else $error("match did not end the scan");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");
`endif

endmodule

>>> rtl/bms_step.sv
// Single-character scan step: lexical machine, nesting depth and result decode.
module bms_step
  import bms_pkg::*;
(
  input  item_t       item,
  input  scan_state_t cur,
  output scan_state_t nxt,
  output result_t     res
);

  always_comb begin
    logic            two;
    logic [CH_W-1:0] same_ch;
    logic [CH_W-1:0] target_ch;
    nxt       = cur;
    res       = '{status: ST_SEARCH, match_position: '0};
    two       = 1'b0;
    same_ch   = kind_char(cur.kind);
    target_ch = kind_char(partner_of(cur.kind));

    if (item.start_scan) begin
      nxt.lex   = LX_NORMAL;
      nxt.depth = '0;
      nxt.skip  = 1'b0;
      nxt.kind  = kind_of(item.ch);
      if (nxt.kind == KIND_NONE) begin
        nxt.done   = 1'b1;
        res.status = ST_NOTBR;
      end else begin
        nxt.done = item.last_in_scan;
      end
    end else if (cur.done || cur.kind == KIND_NONE) begin
      res.status = ST_IDLE;
    end else if (cur.skip) begin
      // drop the second half of a two-character token
      nxt.skip = 1'b0;
    end else begin
      unique case (cur.lex)
        LX_NORMAL: begin
          if (item.ch == CH_DQUOTE) begin
            nxt.lex = LX_STRING;
          end else if (item.ch == CH_SQUOTE) begin
            nxt.lex = LX_CHAR;
          end else if (item.ch == CH_SLASH && item.has_after) begin
            if (item.ch_after == CH_SLASH) begin
              nxt.lex = LX_LINE;
              two     = 1'b1;
            end else if (item.ch_after == CH_STAR) begin
              nxt.lex = LX_BLOCK;
              two     = 1'b1;
            end
          end else if (item.ch == same_ch) begin
            if (cur.depth != '1) nxt.depth = cur.depth + 1'b1;
          end else if (item.ch == target_ch) begin
            if (cur.depth == '0) begin
              res.status         = ST_FOUND;
              res.match_position = item.position;
              nxt.done           = 1'b1;
            end else begin
              nxt.depth = cur.depth - 1'b1;
            end
          end
        end
        LX_STRING: begin
          if (item.ch == CH_DQUOTE && (!item.has_before || item.ch_before != CH_BSLASH))
            nxt.lex = LX_NORMAL;
        end
        LX_CHAR: begin
          if (item.ch == CH_SQUOTE && (!item.has_before || item.ch_before != CH_BSLASH))
            nxt.lex = LX_NORMAL;
        end
        LX_LINE: begin
          if (item.ch == CH_NL) nxt.lex = LX_NORMAL;
        end
        LX_BLOCK: begin
          if (item.ch == CH_STAR && item.has_after && item.ch_after == CH_SLASH) begin
            nxt.lex = LX_NORMAL;
            two     = 1'b1;
          end
        end
        default: nxt.lex = LX_NORMAL;
      endcase
      // skip only on forward scans (opening bracket kinds are odd)
      if (two && cur.kind[0]) nxt.skip = 1'b1;
    end

    if (res.status == ST_SEARCH && item.last_in_scan) begin
      res.status = ST_NOMATCH;
      nxt.done   = 1'b1;
      nxt.skip   = 1'b0;
    end
  end

endmodule
